/* rtl/core/slwm_pkg.sv */
// shared types and constants for the segment list with merge
package slwm_pkg;

	localparam int APB_AW = 3;
	localparam logic CFG_MERGE_GAP = 1'b0;

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_TRIM   = 3'd2,
		CMD_APPEND = 3'd3,
		CMD_MERGE  = 3'd4,
		CMD_INSERT = 3'd5,
		CMD_READ   = 3'd6
	} cmd_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOVE,
		ST_WRITE_NEW,
		ST_MERGE_RD,
		ST_MERGE_CMP,
		ST_READ_RD,
		ST_FINISH
	} state_e;

	typedef struct packed {
		logic        [15:0] xstart;
		logic signed [15:0] ystart;
		logic        [15:0] xend;
		logic signed [15:0] yend;
		logic        [7:0]  mode;
		logic signed [15:0] score;
	} seg_t;

	typedef struct packed {
		logic        [2:0]  command;
		logic        [4:0]  index;
		logic        [5:0]  amount;
		logic        [15:0] xstart;
		logic signed [15:0] ystart;
		logic        [15:0] xend;
		logic signed [15:0] yend;
		logic        [7:0]  seg_mode;
		logic signed [15:0] score;
	} cmd_t;

	typedef struct packed {
		logic               status;
		logic        [5:0]  length;
		logic        [15:0] out_xstart;
		logic signed [15:0] out_ystart;
		logic        [15:0] out_xend;
		logic signed [15:0] out_yend;
		logic        [7:0]  out_mode;
		logic signed [15:0] out_score;
	} rsp_t;

endpackage

/* rtl/core/slwm_if.sv */
// request and response channel interfaces of the segment list
interface slwm_cmd_if;
	import slwm_pkg::*;
	logic valid;
	logic ready;
	cmd_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface slwm_rsp_if;
	import slwm_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/slwm_store.sv */
// segment storage: one write port, one registered read port
module slwm_store #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  slwm_pkg::seg_t  wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output slwm_pkg::seg_t  rdata
);
	import slwm_pkg::*;

	seg_t mem_q [DEPTH];
	seg_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/segment_list_with_merge.sv */
// segment list with merge: sequencer, entry mover and configuration port
// throughput: one request at a time, entries move one per cycle through the store's
// read and write ports (read one cycle, write the next, overlapped), so shifts set the rate
// reset: entry count and merge_gap clear; store contents stay undefined until written
module segment_list_with_merge #(
	parameter int CAPACITY = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [slwm_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	slwm_cmd_if.sink                      cmd,
	slwm_rsp_if.source                    rsp
);
	import slwm_pkg::*;

	// count needs to hold CAPACITY itself, addresses only reach CAPACITY-1
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	// working width for index/amount/count arithmetic (index + amount reaches 94)
	localparam int WW = ((CW > 7) ? CW : 7) + 1;

	// ---------------------------------------------------------------------
	// configuration register
	// ---------------------------------------------------------------------
	logic [15:0] gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == CFG_MERGE_GAP)) begin
			gap_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_MERGE_GAP) ? {16'b0, gap_q} : 32'b0;

	// ---------------------------------------------------------------------
	// state
	// ---------------------------------------------------------------------
	state_e          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   rem_q, rem_d;         // moves still to issue
	logic [AW-1:0]   src_q, src_d;
	logic [AW-1:0]   dst_q, dst_d;
	logic            up_q, up_d;           // shift direction: toward higher addresses
	logic            new_pend_q, new_pend_d; // new segment written once moves finish
	logic [AW-1:0]   new_addr_q, new_addr_d;
	logic            wpend_s1, wpend_d;    // move read last cycle, write now
	logic [AW-1:0]   waddr_s1, waddr_d;
	logic            status_q, status_d;
	logic            rd_ok_q, rd_ok_d;
	logic [4:0]      idx_q, idx_d;
	seg_t            seg_q, seg_d;
	logic            out_valid_q, out_valid_d;
	rsp_t            out_q, out_d;

	// memory port
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	seg_t            mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	seg_t            mem_rdata;

	slwm_store #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// widened operands
	logic [WW-1:0]      idx_w, amt_w, cnt_w, diff_w, nc_w;
	logic               full;
	logic               do_push;
	// merge tests on the last entry, signed 18-bit differences
	logic signed [17:0] gap_v, len_v, lim_v;

	assign cmd.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

	assign idx_w = WW'(cmd.payload.index);
	assign amt_w = WW'(cmd.payload.amount);
	assign cnt_w = WW'(count_q);
	// count minus amount, floored at zero (trim, and the remove bound)
	assign diff_w = (cnt_w > amt_w) ? (cnt_w - amt_w) : '0;
	// remove never shrinks the list below the index
	assign nc_w = (diff_w < idx_w) ? idx_w : diff_w;
	assign full = (cnt_w >= WW'(CAPACITY));

	assign gap_v = $signed({2'b00, seg_q.xstart}) - $signed({2'b00, mem_rdata.xend});
	assign len_v = $signed({2'b00, mem_rdata.xend}) - $signed({2'b00, mem_rdata.xstart});
	assign lim_v = $signed({2'b00, gap_q});

	// ---------------------------------------------------------------------
	// sequencer: next state, memory port and datapath updates
	// ---------------------------------------------------------------------
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		rem_d       = rem_q;
		src_d       = src_q;
		dst_d       = dst_q;
		up_d        = up_q;
		new_pend_d  = new_pend_q;
		new_addr_d  = new_addr_q;
		wpend_d     = 1'b0;
		waddr_d     = dst_q;
		status_d    = status_q;
		rd_ok_d     = rd_ok_q;
		idx_d       = idx_q;
		seg_d       = seg_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !rsp.ready;
		do_push     = 1'b0;

		// a move read last cycle lands this cycle
		mem_we    = wpend_s1;
		mem_waddr = waddr_s1;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = src_q;

		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					idx_d      = cmd.payload.index;
					seg_d      = '{xstart: cmd.payload.xstart, ystart: cmd.payload.ystart,
						xend: cmd.payload.xend, yend: cmd.payload.yend,
						mode: cmd.payload.seg_mode, score: cmd.payload.score};
					status_d   = 1'b0;
					rd_ok_d    = 1'b0;
					new_pend_d = 1'b0;
					state_d    = ST_FINISH;
					case (cmd.payload.command)
						CMD_CLEAR: begin
							count_d = '0;
						end
						CMD_REMOVE: begin
							if (idx_w < cnt_w) begin
								count_d = CW'(nc_w);
								if (nc_w > idx_w) begin
									// close the gap: pull entries down from index + amount
									src_d   = AW'(idx_w + amt_w);
									dst_d   = AW'(idx_w);
									rem_d   = CW'(nc_w - idx_w);
									up_d    = 1'b0;
									state_d = ST_MOVE;
								end
							end else begin
								status_d = 1'b1;
							end
						end
						CMD_TRIM: begin
							count_d = CW'(diff_w);
						end
						CMD_APPEND: begin
							do_push = 1'b1;
						end
						CMD_MERGE: begin
							if (count_q == '0) begin
								do_push = 1'b1;
							end else begin
								state_d = ST_MERGE_RD;
							end
						end
						CMD_INSERT: begin
							if (idx_w < cnt_w) begin
								new_pend_d = 1'b1;
								up_d       = !full;
								state_d    = ST_MOVE;
								if (full) begin
									// drop the oldest, slide 1..index-1 down, new one
									// lands just before the old entry at index
									src_d = AW'(1);
									dst_d = '0;
									if (idx_w == '0) begin
										rem_d      = '0;
										new_addr_d = '0;
									end else begin
										rem_d      = CW'(idx_w - WW'(1));
										new_addr_d = AW'(idx_w - WW'(1));
									end
								end else begin
									// open a hole at index, moving from the top down
									src_d      = AW'(cnt_w - WW'(1));
									dst_d      = AW'(cnt_w);
									rem_d      = CW'(cnt_w - idx_w);
									new_addr_d = AW'(idx_w);
									count_d    = CW'(cnt_w + WW'(1));
								end
							end else if (idx_w == cnt_w) begin
								do_push = 1'b1;
							end else begin
								status_d = 1'b1;
							end
						end
						CMD_READ: begin
							if (idx_w < cnt_w) begin
								state_d = ST_READ_RD;
							end else begin
								status_d = 1'b1;
							end
						end
						default: begin
							state_d = ST_FINISH;
						end
					endcase
				end
			end
			ST_MOVE: begin
				if (rem_q != '0) begin
					mem_re  = 1'b1;
					wpend_d = 1'b1;
					waddr_d = dst_q;
					rem_d   = rem_q - CW'(1);
					if (up_q) begin
						src_d = src_q - AW'(1);
						dst_d = dst_q - AW'(1);
					end else begin
						src_d = src_q + AW'(1);
						dst_d = dst_q + AW'(1);
					end
				end else if (!wpend_s1) begin
					state_d = new_pend_q ? ST_WRITE_NEW : ST_FINISH;
				end
			end
			ST_WRITE_NEW: begin
				mem_we    = 1'b1;
				mem_waddr = new_addr_q;
				mem_wdata = seg_q;
				state_d   = ST_FINISH;
			end
			ST_MERGE_RD: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(cnt_w - WW'(1));
				state_d   = ST_MERGE_CMP;
			end
			ST_MERGE_CMP: begin
				state_d = ST_FINISH;
				if (gap_v <= lim_v) begin
					// close enough: stretch the last segment to the new end
					mem_we    = 1'b1;
					mem_waddr = AW'(cnt_w - WW'(1));
					mem_wdata = mem_rdata;
					mem_wdata.xend = seg_q.xend;
					mem_wdata.yend = seg_q.yend;
				end else if (len_v <= lim_v) begin
					// last segment is short: replace it
					mem_we    = 1'b1;
					mem_waddr = AW'(cnt_w - WW'(1));
					mem_wdata = seg_q;
				end else begin
					do_push = 1'b1;
				end
			end
			ST_READ_RD: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(idx_q);
				rd_ok_d   = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_d       = 1'b1;
					out_d             = '0;
					out_d.status      = status_q;
					out_d.length      = 6'(count_q);
					if (rd_ok_q) begin
						out_d.out_xstart = mem_rdata.xstart;
						out_d.out_ystart = mem_rdata.ystart;
						out_d.out_xend   = mem_rdata.xend;
						out_d.out_yend   = mem_rdata.yend;
						out_d.out_mode   = mem_rdata.mode;
						out_d.out_score  = mem_rdata.score;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// push to the tail; a full list first drops the oldest entry
		if (do_push) begin
			if (full) begin
				src_d      = AW'(1);
				dst_d      = '0;
				rem_d      = CW'(CAPACITY - 1);
				up_d       = 1'b0;
				new_addr_d = AW'(CAPACITY - 1);
				new_pend_d = 1'b1;
				state_d    = ST_MOVE;
			end else begin
				new_addr_d = AW'(cnt_w);
				count_d    = CW'(cnt_w + WW'(1));
				state_d    = ST_WRITE_NEW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rem_q       <= '0;
			new_pend_q  <= 1'b0;
			wpend_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= 1'b0;
			rd_ok_q     <= 1'b0;
		end else begin
			count_q     <= count_d;
			rem_q       <= rem_d;
			new_pend_q  <= new_pend_d;
			wpend_s1    <= wpend_d;
			out_valid_q <= out_valid_d;
			status_q    <= status_d;
			rd_ok_q     <= rd_ok_d;
		end
	end

	// payload and pointers
	always_ff @(posedge clk) begin
		src_q      <= src_d;
		dst_q      <= dst_d;
		up_q       <= up_d;
		new_addr_q <= new_addr_d;
		waddr_s1   <= waddr_d;
		idx_q      <= idx_d;
		seg_q      <= seg_d;
		out_q      <= out_d;
	end

endmodule

/* verif/tb_top.sv */
// testbench for the segment list with merge: directed and random requests checked against a predictor
module tb_top;
	import slwm_pkg::*;

	localparam int CAPACITY = 32;
	// merge_gap is register 0, every register is 32 bits wide, so byte address 4*i
	localparam logic [APB_AW-1:0] GAP_ADDR = APB_AW'(4 * CFG_MERGE_GAP);
	// overall simulation time limit for the run
	localparam int RUN_LIMIT = 4_000_000;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	slwm_cmd_if cmd_ch ();
	slwm_rsp_if rsp_ch ();

	segment_list_with_merge #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd(cmd_ch.sink),
		.rsp(rsp_ch.source)
	);

	always #4 clk = ~clk;

	// shadow copy of the list, its length and the merge threshold
	seg_t seg_list[CAPACITY];
	int seg_count = 0;
	logic [15:0] merge_gap_cfg = 16'd0;

	// responses still owed by the block, oldest first
	rsp_t rsp_due[$];

	bit failed = 1'b0;
	bit idle_on = 1'b1;	// random gaps on both channels
	int rx_hold = 0;	// long receiver hold-off, counted down by the receiver
	int rx_stall = 0;	// remaining cycles of a short receiver stall

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// append at the tail, dropping the oldest entry when the list is full
	function automatic void push_segment(seg_t s);
		if (seg_count >= CAPACITY) begin
			for (int i = 0; i < CAPACITY - 1; i++)
				seg_list[i] = seg_list[i + 1];
			seg_count--;
		end
		seg_list[seg_count] = s;
		seg_count++;
	endfunction

	// apply one request to the shadow list and return the response it earns
	function automatic rsp_t list_apply(cmd_t c);
		rsp_t r;
		seg_t s;
		int idx;
		int amt;
		int keep;
		int gap_x;
		int span_x;
		int gap_lim;
		r = '0;
		s = '{c.xstart, c.ystart, c.xend, c.yend, c.seg_mode, c.score};
		idx = c.index;
		amt = c.amount;
		gap_lim = merge_gap_cfg;
		case (cmd_e'(c.command))
			CMD_CLEAR: seg_count = 0;
			CMD_REMOVE: begin
				if (idx < seg_count) begin
					// never shrink below the index, close the gap from index + amount
					keep = (seg_count > amt) ? seg_count - amt : 0;
					if (keep < idx)
						keep = idx;
					for (int i = idx; i < keep; i++)
						seg_list[i] = seg_list[i + amt];
					seg_count = keep;
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_TRIM: seg_count = (seg_count > amt) ? seg_count - amt : 0;
			CMD_APPEND: push_segment(s);
			CMD_MERGE: begin
				if (seg_count == 0) begin
					push_segment(s);
				end else begin
					// signed differences of unsigned positions
					gap_x = int'(c.xstart) - int'(seg_list[seg_count - 1].xend);
					span_x = int'(seg_list[seg_count - 1].xend)
						- int'(seg_list[seg_count - 1].xstart);
					if (gap_x <= gap_lim) begin
						seg_list[seg_count - 1].xend = c.xend;
						seg_list[seg_count - 1].yend = c.yend;
					end else if (span_x <= gap_lim) begin
						seg_list[seg_count - 1] = s;
					end else begin
						push_segment(s);
					end
				end
			end
			CMD_INSERT: begin
				if (idx < seg_count) begin
					if (seg_count >= CAPACITY) begin
						// full: oldest goes, new one lands just before the old entry at index
						if (idx == 0) begin
							seg_list[0] = s;
						end else begin
							for (int i = 0; i < idx - 1; i++)
								seg_list[i] = seg_list[i + 1];
							seg_list[idx - 1] = s;
						end
					end else begin
						for (int i = seg_count; i > idx; i--)
							seg_list[i] = seg_list[i - 1];
						seg_list[idx] = s;
						seg_count++;
					end
				end else if (idx == seg_count) begin
					push_segment(s);
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_READ: begin
				if (idx < seg_count) begin
					r.out_xstart = seg_list[idx].xstart;
					r.out_ystart = seg_list[idx].ystart;
					r.out_xend = seg_list[idx].xend;
					r.out_yend = seg_list[idx].yend;
					r.out_mode = seg_list[idx].mode;
					r.out_score = seg_list[idx].score;
				end else begin
					r.status = 1'b1;
				end
			end
			default: ;
		endcase
		r.length = 6'(seg_count);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// monitor: predict on request accept, check on response accept
	// ---------------------------------------------------------------

	function automatic void check_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				rsp_due.push_back(list_apply(cmd_ch.payload));
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.payload;
				if (rsp_due.size() == 0) begin
					$error("response with no request outstanding");
					failed = 1'b1;
				end else begin
					want = rsp_due.pop_front();
					check_field("status", want.status, got.status);
					check_field("length", want.length, got.length);
					check_field("out_xstart", want.out_xstart, got.out_xstart);
					check_field("out_ystart", want.out_ystart, got.out_ystart);
					check_field("out_xend", want.out_xend, got.out_xend);
					check_field("out_yend", want.out_yend, got.out_yend);
					check_field("out_mode", want.out_mode, got.out_mode);
					check_field("out_score", want.out_score, got.out_score);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// response side: random short stalls plus an optional long hold-off
	// ---------------------------------------------------------------

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_hold--;
			end else if (rx_stall > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_stall--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				// start a stall of random length
				rsp_ch.ready <= 1'b0;
				rx_stall = $urandom_range(0, 3);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// request side and configuration port
	// ---------------------------------------------------------------

	// offer one request, with an optional gap first, and return once it is taken
	task automatic send_item(cmd_t c);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= c;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_op(cmd_e op, int idx, int amt, seg_t s);
		cmd_t c;
		c.command = op;
		c.index = 5'(idx);
		c.amount = 6'(amt);
		c.xstart = s.xstart;
		c.ystart = s.ystart;
		c.xend = s.xend;
		c.yend = s.yend;
		c.seg_mode = s.mode;
		c.score = s.score;
		send_item(c);
	endtask

	// stop offering and wait until every owed response has come back
	task automatic wait_list_idle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write merge_gap, then read it back; only called while the block is idle
	task automatic set_merge_gap(logic [15:0] value);
		logic [31:0] rd;
		wait_list_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= GAP_ADDR;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register takes the value at this edge
		merge_gap_cfg = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[15:0] !== value) begin
			$error("merge_gap readback: expected %0d, got %0d", value, rd[15:0]);
			failed = 1'b1;
		end
	endtask

	function automatic seg_t mk_seg(int xs, int ys, int xe, int ye, int mode, int score);
		return '{16'(xs), 16'(ys), 16'(xe), 16'(ye), 8'(mode), 16'(score)};
	endfunction

	function automatic seg_t rand_seg();
		return '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom), 16'($urandom)};
	endfunction

	// random request: mostly valid indexes and small amounts, merge positions
	// placed near the current tail so all three merge outcomes show up
	function automatic cmd_t random_command();
		cmd_t c;
		int pick;
		int top;
		logic [15:0] anchor;
		seg_t s;
		s = rand_seg();
		pick = $urandom_range(0, 99);
		if (pick < 2)
			c.command = CMD_CLEAR;
		else if (pick < 10)
			c.command = CMD_REMOVE;
		else if (pick < 16)
			c.command = CMD_TRIM;
		else if (pick < 40)
			c.command = CMD_APPEND;
		else if (pick < 62)
			c.command = CMD_MERGE;
		else if (pick < 78)
			c.command = CMD_INSERT;
		else
			c.command = CMD_READ;
		top = (seg_count > 31) ? 31 : seg_count;
		if ($urandom_range(0, 9) < 8)
			c.index = 5'($urandom_range(0, top));
		else
			c.index = 5'($urandom_range(0, 31));
		if ($urandom_range(0, 3) != 0)
			c.amount = 6'($urandom_range(0, 4));
		else
			c.amount = 6'($urandom_range(0, 32));
		if (seg_count > 0)
			anchor = seg_list[seg_count - 1].xend;
		else
			anchor = s.xstart;
		if ($urandom_range(0, 1) == 1)
			c.xstart = anchor + 16'($urandom_range(0, 300)) - 16'd100;
		else
			c.xstart = s.xstart;
		if ($urandom_range(0, 1) == 1)
			c.xend = c.xstart + 16'($urandom_range(0, 400));
		else
			c.xend = s.xend;
		c.ystart = s.ystart;
		c.yend = s.yend;
		c.seg_mode = s.mode;
		c.score = s.score;
		return c;
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// empty-list failures, inserts at, above and below the count, reads, removes, trims
	task automatic test_basic_edits();
		seg_t lo;
		seg_t hi;
		lo = mk_seg(0, -32768, 65535, 32767, 255, -32768);
		hi = mk_seg(65535, 32767, 0, -32768, 0, 32767);
		send_op(CMD_READ, 0, 0, lo);		// empty: out of range
		send_op(CMD_REMOVE, 0, 1, lo);		// empty: out of range
		send_op(CMD_TRIM, 31, 32, hi);
		send_op(CMD_APPEND, 0, 0, lo);
		send_op(CMD_APPEND, 31, 32, hi);
		send_op(CMD_INSERT, 2, 0, rand_seg());	// index equal to count appends
		send_op(CMD_INSERT, 4, 0, rand_seg());	// above count
		send_op(CMD_INSERT, 31, 0, rand_seg());
		send_op(CMD_INSERT, 1, 0, rand_seg());
		send_op(CMD_INSERT, 0, 0, rand_seg());
		for (int i = 0; i < 6; i++)
			send_op(CMD_READ, i, 0, lo);
		send_op(CMD_REMOVE, 1, 2, hi);
		send_op(CMD_REMOVE, 0, 0, hi);
		send_op(CMD_REMOVE, 1, 32, hi);		// amount past the end
		send_op(CMD_READ, 0, 0, hi);
		send_op(CMD_READ, 31, 0, hi);
		send_op(CMD_TRIM, 0, 1, hi);
		send_op(CMD_CLEAR, 0, 0, hi);
	endtask

	// extend, replace and append outcomes of merge-append at several thresholds
	task automatic test_merge_rules();
		set_merge_gap(16'd0);
		send_op(CMD_CLEAR, 0, 0, rand_seg());
		send_op(CMD_MERGE, 0, 0, mk_seg(100, -5, 200, 5, 1, 10));	// empty list
		send_op(CMD_MERGE, 0, 0, mk_seg(200, 7, 260, 8, 2, 11));	// touching: extend
		send_op(CMD_MERGE, 0, 0, mk_seg(150, 9, 300, -9, 3, 12));	// overlap: extend
		send_op(CMD_MERGE, 0, 0, mk_seg(5000, 1, 5000, 2, 4, 13));	// long tail: append
		send_op(CMD_MERGE, 0, 0, mk_seg(6000, 3, 7000, 4, 5, 14));	// zero-length tail: replace
		send_op(CMD_MERGE, 0, 0, mk_seg(9000, 5, 9100, 6, 6, 15));
		for (int i = 0; i < 3; i++)
			send_op(CMD_READ, i, 0, rand_seg());
		// widest threshold: every merge extends
		set_merge_gap(16'hffff);
		send_op(CMD_MERGE, 0, 0, mk_seg(65535, 1, 65535, 2, 7, 16));
		send_op(CMD_MERGE, 0, 0, mk_seg(0, 3, 10, 4, 8, 17));
		send_op(CMD_READ, 2, 0, rand_seg());
		set_merge_gap(16'd100);
		send_op(CMD_APPEND, 0, 0, mk_seg(1000, 1, 900, 2, 9, 18));	// negative length
		send_op(CMD_MERGE, 0, 0, mk_seg(2000, 3, 2300, 4, 10, 19));	// replace
		send_op(CMD_MERGE, 0, 0, mk_seg(2400, 5, 2600, 6, 11, 20));	// gap at threshold
		send_op(CMD_MERGE, 0, 0, mk_seg(2701, 7, 2800, 8, 12, 21));	// one past: append
		send_op(CMD_READ, 3, 0, rand_seg());
		send_op(CMD_READ, 4, 0, rand_seg());
	endtask

	// fill past capacity, then the full-list insert rules
	task automatic test_full_list();
		send_op(CMD_CLEAR, 0, 0, rand_seg());
		repeat (CAPACITY + 2)
			send_op(CMD_APPEND, 0, 0, rand_seg());
		send_op(CMD_READ, 0, 0, rand_seg());
		send_op(CMD_READ, 31, 0, rand_seg());
		send_op(CMD_INSERT, 0, 0, rand_seg());
		send_op(CMD_INSERT, 1, 0, rand_seg());
		send_op(CMD_INSERT, 31, 0, rand_seg());
		send_op(CMD_INSERT, 17, 0, rand_seg());
		foreach (seg_list[i])
			if (i < 3 || i > 28 || i == 16 || i == 17)
				send_op(CMD_READ, i, 0, rand_seg());
		send_op(CMD_MERGE, 0, 0, mk_seg(0, 0, 0, 0, 0, 0));
		send_op(CMD_REMOVE, 31, 1, rand_seg());
		send_op(CMD_INSERT, 31, 0, rand_seg());		// at count on 31 entries
		send_op(CMD_READ, 31, 0, rand_seg());
	endtask

	// random phases at different thresholds; one phase holds the response side
	// off so requests back up, the last runs without any idling
	task automatic test_random_traffic();
		logic [15:0] gaps[6];
		gaps[0] = 16'd0;
		gaps[1] = 16'hffff;
		gaps[2] = 16'($urandom_range(0, 200));
		gaps[3] = 16'($urandom);
		gaps[4] = 16'd50;
		gaps[5] = 16'd300;
		for (int p = 0; p < 6; p++) begin
			set_merge_gap(gaps[p]);
			if (p == 5)
				idle_on = 1'b0;
			if (p == 4)
				rx_hold = 400;
			repeat (150)
				send_item(random_command());
		end
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.payload <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_edits();
		test_merge_rules();
		test_full_list();
		test_random_traffic();
		wait_list_idle();
		repeat (40) @(posedge clk);
		if (!failed && rsp_due.size() == 0)
			$display("** segment_list_with_merge: PASSED **");
		else
			$display("** segment_list_with_merge: FAILED **");
		$finish;
	end

	initial begin
		#RUN_LIMIT;
		$display("** segment_list_with_merge: FAILED **");
		$finish;
	end

endmodule

/* segment_list_with_merge.f */
rtl/core/slwm_pkg.sv
rtl/core/slwm_if.sv
rtl/core/slwm_store.sv
rtl/core/segment_list_with_merge.sv
verif/tb_top.sv
